// ----- design/dsgb_pkg.sv -----
package dsgb_pkg;

    localparam int PAGE_BYTES = 4096;
    localparam int ADDR_BITS  = 32;
    localparam int MAX_SEGS   = 256;

    // address bits actually carried (phys_addr is 32 bits wide)
    localparam int AW       = (ADDR_BITS < 32) ? ADDR_BITS : 32;
    localparam int PB       = $clog2(PAGE_BYTES);
    localparam int SLOT_CAP = (MAX_SEGS < 256) ? MAX_SEGS : 256;

    localparam logic [31:0] BOUNDARY_RST = 32'd0;
    localparam logic [23:0] MAX_SIZE_RST = 24'd65536;
    localparam logic [8:0]  MAX_SEGS_RST = 9'd16;

    typedef enum logic [1:0] {
        REG_BOUNDARY = 2'd0,
        REG_MAX_SIZE = 2'd1,
        REG_MAX_SEGS = 2'd2
    } t_reg_idx;

    localparam logic KIND_PIECE  = 1'b0;
    localparam logic KIND_FINISH = 1'b1;

    typedef struct packed {
        logic [31:0] boundary;
        logic [23:0] max_size;
        logic [8:0]  max_segs;
    } t_cfg;

    typedef struct packed {
        logic        kind;
        logic [31:0] phys_addr;
        logic [23:0] remaining;
        logic        first;
    } t_item;

    typedef struct packed {
        logic [AW-1:0] open_addr;
        logic [23:0]   open_len;
        logic [AW-1:0] next_addr;
        logic [7:0]    slot;
        logic          open;
        logic          ovf;
    } t_list_state;

    typedef struct packed {
        logic [8:0]  seg_count;
        logic        status;
        logic [7:0]  closed_index;
        logic [23:0] closed_len;
        logic [31:0] closed_addr;
        logic        closed_valid;
        logic [23:0] consumed;
    } t_result;

    localparam t_list_state LIST_CLEAR = '0;

endpackage

// ----- design/dma_scatter_gather_builder.sv -----
// Scatter-gather list builder.
// Slave stream: one item per piece of buffer (tuser = kind, 0 piece, 1 finish).
//   A piece carries the physical address, the bytes remaining and a first flag
//   that starts a new list. A finish flushes the open segment and clears the list.
// Master stream: exactly one result item per input item, carrying the bytes
//   consumed, an optional closed segment (address, length, slot), the sticky
//   too-many-segments status and, on finish, the segment count.
// Config port: i_cfg_wr_en/i_cfg_index/i_cfg_data write boundary (0),
//   max_segment_size (1) and max_segments (2); write only while idle.
// Pipeline: an accepted item passes the input register, then the result register,
//   which raises o_m_tvalid. Throughput: one item per cycle while the receiver
//   keeps i_m_tready high, as the next open-segment state is computed combinationally.
// Reset (synchronous, i_rst_n low): list state and both stages empty,
//   registers back to boundary 0, max size 65536, 16 slots.
// When the receiver stalls the result stays in the output register, the input
//   register still fills, and o_s_tready drops once both are held.
module dma_scatter_gather_builder
    import dsgb_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_wr_en,
    input  logic [1:0]   i_cfg_index,
    input  logic [31:0]  i_cfg_data,
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    input  logic [63:0]  i_s_tdata,   // phys_addr[31:0], remaining[55:32], first[56]
    input  logic         i_s_tuser,   // kind
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    output logic [103:0] o_m_tdata    // consumed[23:0], closed_valid[24],
                                      // closed_addr[56:25], closed_len[80:57],
                                      // closed_index[88:81], status[89],
                                      // seg_count[98:90]
);

    t_cfg        r_cfg;
    t_list_state r_state;
    t_list_state n_state;
    t_item       r_item;
    logic        r_in_valid;
    t_result     r_out;
    t_result     n_out;
    logic        r_out_valid;
    logic        fire;

    assign fire       = r_in_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready = !r_in_valid || fire;
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {5'd0, r_out};

    dsgb_step u_step (
        .i_cfg    (r_cfg),
        .i_item   (r_item),
        .i_state  (r_state),
        .o_state  (n_state),
        .o_result (n_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.boundary <= BOUNDARY_RST;
            r_cfg.max_size <= MAX_SIZE_RST;
            r_cfg.max_segs <= MAX_SEGS_RST;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                REG_BOUNDARY: r_cfg.boundary <= i_cfg_data;
                REG_MAX_SIZE: r_cfg.max_size <= i_cfg_data[23:0];
                REG_MAX_SEGS: r_cfg.max_segs <= i_cfg_data[8:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= LIST_CLEAR;
        end else begin
            if (o_s_tready) begin
                r_in_valid <= i_s_tvalid;
            end
            if (fire) begin
                r_out_valid <= 1'b1;
                r_state     <= n_state;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_item.kind      <= i_s_tuser;
            r_item.phys_addr <= i_s_tdata[31:0];
            r_item.remaining <= i_s_tdata[55:32];
            r_item.first     <= i_s_tdata[56];
        end
        if (fire) begin
            r_out <= n_out;
        end
    end

endmodule

// ----- design/dsgb_step.sv -----
module dsgb_step
    import dsgb_pkg::*;
(
    input  t_cfg        i_cfg,
    input  t_item       i_item,
    input  t_list_state i_state,
    output t_list_state o_state,
    output t_result     o_result
);

    logic [AW-1:0] cur;
    t_list_state   eff;
    logic [PB:0]   page_left;
    logic [23:0]   chunk;
    logic [AW-1:0] bnd;
    logic [AW-1:0] bmask;
    logic [AW-1:0] bend;
    logic [AW-1:0] win_left;
    logic [24:0]   sum;
    logic [8:0]    lim;
    logic          contig;
    logic          bnd_ok;

    always_comb begin
        cur       = i_item.phys_addr[AW-1:0];
        eff       = i_item.first ? LIST_CLEAR : i_state;
        page_left = (PB+1)'(PAGE_BYTES) - {1'b0, cur[PB-1:0]};
        chunk     = (24'(page_left) > i_item.remaining) ? i_item.remaining
                                                        : 24'(page_left);
        bnd       = i_cfg.boundary[AW-1:0];
        bmask     = ~(bnd - AW'(1));
        bend      = (cur + bnd) & bmask;
        win_left  = bend - cur;
        if (i_cfg.boundary != 32'd0 && win_left != '0 && 32'(chunk) > 32'(win_left)) begin
            chunk = 24'(win_left);
        end
        sum    = {1'b0, eff.open_len} + {1'b0, chunk};
        lim    = (i_cfg.max_segs > 9'(SLOT_CAP)) ? 9'(SLOT_CAP) : i_cfg.max_segs;
        contig = (cur == eff.next_addr) && (sum <= {1'b0, i_cfg.max_size});
        bnd_ok = (i_cfg.boundary == 32'd0) || ((eff.open_addr & bmask) == (cur & bmask));

        o_state  = eff;
        o_result = '0;

        if (i_item.kind == KIND_FINISH) begin
            if (!i_state.ovf && i_state.open) begin
                o_result.closed_valid = 1'b1;
                o_result.closed_addr  = 32'(i_state.open_addr);
                o_result.closed_len   = i_state.open_len;
                o_result.closed_index = i_state.slot;
                o_result.seg_count    = {1'b0, i_state.slot} + 9'd1;
            end
            o_result.status = i_state.ovf;
            o_state         = LIST_CLEAR;
        end else begin
            if (i_item.remaining != 24'd0 && !eff.ovf) begin
                o_result.consumed = chunk;
                o_state.next_addr = cur + AW'(chunk);
                if (!eff.open) begin
                    o_state.open_addr = cur;
                    o_state.open_len  = chunk;
                    o_state.open      = 1'b1;
                end else if (contig && bnd_ok) begin
                    o_state.open_len = sum[23:0];
                end else if ({1'b0, eff.slot} + 9'd1 >= lim) begin
                    // out of slots: chunk not taken, list goes sticky
                    o_state.ovf       = 1'b1;
                    o_state.open      = 1'b0;
                    o_state.next_addr = eff.next_addr;
                    o_result.consumed = 24'd0;
                end else begin
                    o_result.closed_valid = 1'b1;
                    o_result.closed_addr  = 32'(eff.open_addr);
                    o_result.closed_len   = eff.open_len;
                    o_result.closed_index = eff.slot;
                    o_state.slot          = eff.slot + 8'd1;
                    o_state.open_addr     = cur;
                    o_state.open_len      = chunk;
                end
            end
            o_result.status = o_state.ovf;
        end
    end

endmodule

// ----- test/tb_dma_scatter_gather_builder.sv -----
module tb_dma_scatter_gather_builder;
    import dsgb_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [31:0] ADDR_MASK = (AW >= 32) ? 32'hFFFF_FFFF : ((32'd1 << AW) - 32'd1);
    localparam int QUIET_LIMIT = 4000;
    localparam int HOLD_CYCLES = 60;

    class sg_list_shadow;
        logic [31:0] bnd;
        logic [23:0] seg_max;
        logic [8:0]  slots_cfg;
        logic [31:0] open_addr;
        logic [23:0] open_len;
        logic [31:0] next_addr;
        logic [7:0]  slot;
        bit          open_seg;
        bit          ovf;
        t_result     due_results[$];
        logic [23:0] last_consumed;
        int          errors;

        function new();
            bnd       = BOUNDARY_RST;
            seg_max   = MAX_SIZE_RST;
            slots_cfg = MAX_SEGS_RST;
            errors    = 0;
            last_consumed = '0;
            clear_list();
        endfunction

        function void clear_list();
            open_addr = '0;
            open_len  = '0;
            next_addr = '0;
            slot      = '0;
            open_seg  = 1'b0;
            ovf       = 1'b0;
        endfunction

        function void set_reg(t_reg_idx idx, logic [31:0] val);
            case (idx)
                REG_BOUNDARY: bnd       = val;
                REG_MAX_SIZE: seg_max   = val[23:0];
                REG_MAX_SEGS: slots_cfg = val[8:0];
                default: ;
            endcase
        endfunction

        function int pending();
            return due_results.size();
        endfunction

        function void note_item(logic kind, logic [31:0] addr, logic [23:0] len, logic first);
            t_result     r;
            logic [31:0] cur;
            logic [31:0] chunk;
            logic [31:0] bmask;
            logic [31:0] bend;
            logic [31:0] win_left;
            logic [32:0] merged;
            logic [8:0]  lim;
            bit          take;
            r = '0;
            if (kind == KIND_FINISH) begin
                if (!ovf && open_seg) begin
                    r.closed_valid = 1'b1;
                    r.closed_addr  = open_addr;
                    r.closed_len   = open_len;
                    r.closed_index = slot;
                    r.seg_count    = {1'b0, slot} + 9'd1;
                end
                r.status = ovf;
                clear_list();
            end else begin
                if (first)
                    clear_list();
                if (len != 0 && !ovf) begin
                    cur   = addr & ADDR_MASK;
                    chunk = 32'(PAGE_BYTES) - (cur & 32'(PAGE_BYTES - 1));
                    bmask = ~(bnd - 32'd1) & ADDR_MASK;
                    if (chunk > {8'd0, len})
                        chunk = {8'd0, len};
                    if (bnd != 0) begin
                        bend     = ((cur + bnd) & ADDR_MASK) & bmask;
                        win_left = (bend - cur) & ADDR_MASK;
                        if (win_left != 0 && chunk > win_left)
                            chunk = win_left;
                    end
                    lim    = (slots_cfg > 9'(SLOT_CAP)) ? 9'(SLOT_CAP) : slots_cfg;
                    merged = {9'd0, open_len} + {1'b0, chunk};
                    take   = 1'b1;
                    if (!open_seg) begin
                        open_addr = cur;
                        open_len  = chunk[23:0];
                        open_seg  = 1'b1;
                    end else if (cur == next_addr && merged <= {9'd0, seg_max} &&
                                 (bnd == 0 || (open_addr & bmask) == (cur & bmask))) begin
                        open_len = merged[23:0];
                    end else if ({1'b0, slot} + 9'd1 >= lim) begin
                        ovf      = 1'b1;
                        open_seg = 1'b0;
                        take     = 1'b0;
                    end else begin
                        r.closed_valid = 1'b1;
                        r.closed_addr  = open_addr;
                        r.closed_len   = open_len;
                        r.closed_index = slot;
                        slot      = slot + 8'd1;
                        open_addr = cur;
                        open_len  = chunk[23:0];
                    end
                    if (take) begin
                        r.consumed = chunk[23:0];
                        next_addr  = (cur + chunk) & ADDR_MASK;
                    end
                end
                r.status = ovf;
            end
            last_consumed = r.consumed;
            due_results.push_back(r);
        endfunction

        function void match_field(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want) begin
                $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
                errors++;
            end
        endfunction

        function void check_result(logic [103:0] data);
            t_result want;
            t_result got;
            if (due_results.size() == 0) begin
                $error("result item with nothing expected: 0x%0h", data);
                errors++;
                return;
            end
            want = due_results.pop_front();
            got  = t_result'(data[98:0]);
            match_field("consumed", 32'(want.consumed), 32'(got.consumed));
            match_field("closed_valid", 32'(want.closed_valid), 32'(got.closed_valid));
            match_field("closed_addr", want.closed_addr, got.closed_addr);
            match_field("closed_len", 32'(want.closed_len), 32'(got.closed_len));
            match_field("closed_index", 32'(want.closed_index), 32'(got.closed_index));
            match_field("status", 32'(want.status), 32'(got.status));
            match_field("seg_count", 32'(want.seg_count), 32'(got.seg_count));
        endfunction
    endclass

    logic         i_clk       = 1'b0;
    logic         i_rst_n     = 1'b0;
    logic         i_cfg_wr_en = 1'b0;
    logic [1:0]   i_cfg_index = REG_BOUNDARY;
    logic [31:0]  i_cfg_data  = '0;
    logic         i_s_tvalid  = 1'b0;
    logic         o_s_tready;
    logic [63:0]  i_s_tdata   = '0;
    logic         i_s_tuser   = KIND_PIECE;
    logic         o_m_tvalid;
    logic         i_m_tready  = 1'b0;
    logic [103:0] o_m_tdata;

    sg_list_shadow book = new();
    bit calm     = 1'b0;
    bit hold_req = 1'b0;
    int items_sent   = 0;
    int quiet_cycles = 0;

    dma_scatter_gather_builder uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_wr_en(i_cfg_wr_en),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_m_tvalid && i_m_tready)
                book.check_result(o_m_tdata);
            if (i_s_tvalid && o_s_tready)
                book.note_item(i_s_tuser, i_s_tdata[31:0], i_s_tdata[55:32], i_s_tdata[56]);
            if ((o_m_tvalid && i_m_tready) || (i_s_tvalid && o_s_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("tb_dma_scatter_gather_builder: done, errors");
                $finish;
            end
        end
    end

    // result side: random stalls, plus one long hold-off on request
    initial begin
        int hold_left;
        hold_left = 0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_left = HOLD_CYCLES;
                hold_req  = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_m_tready <= 1'b0;
            end else begin
                i_m_tready <= calm || ($urandom_range(99) >= 16);
            end
        end
    end

    task automatic write_reg(t_reg_idx idx, logic [31:0] val);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        book.set_reg(idx, val);
        @(negedge i_clk);
    endtask

    task automatic set_config(logic [31:0] bnd, logic [23:0] seg_max, logic [8:0] slots);
        write_reg(REG_BOUNDARY, bnd);
        write_reg(REG_MAX_SIZE, 32'(seg_max));
        write_reg(REG_MAX_SEGS, 32'(slots));
        i_cfg_wr_en <= 1'b0;
    endtask

    task automatic send_item(logic kind, logic [31:0] addr, logic [23:0] len, logic first);
        while (!calm && $urandom_range(99) < 16) begin
            i_s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= kind;
        i_s_tdata  <= {7'd0, first, len, addr};
        do @(posedge i_clk); while (!o_s_tready);
        items_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_finish();
        send_item(KIND_FINISH, $urandom, 24'($urandom), 1'($urandom));
    endtask

    task automatic settle();
        i_s_tvalid <= 1'b0;
        while (book.pending() != 0)
            @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    function automatic logic [31:0] pick_addr();
        logic [31:0] a;
        a = $urandom;
        case ($urandom_range(4))
            0: a = a & ~32'hFFF;
            1: a = (a & ~32'hFFF) - $urandom_range(1, 16);
            2: if (book.bnd > 1) a = (a & ~(book.bnd - 32'd1)) - $urandom_range(1, 300);
            3: a = 32'hFFFF_FFFF - $urandom_range(0, 9000);
            default: ;
        endcase
        return a;
    endfunction

    function automatic logic [23:0] pick_len();
        case ($urandom_range(11))
            0: return 24'($urandom_range(1, 64));
            1: return 24'($urandom);
            2: return 24'd0;
            default: return 24'($urandom_range(1, 12000));
        endcase
    endfunction

    // disjoint pieces, each one a new segment while slots last
    task automatic scatter(int n);
        for (int k = 0; k < n; k++)
            send_item(KIND_PIECE, $urandom & ~32'hFFF, 24'($urandom_range(1, 4000)), k == 0);
    endtask

    // one load: a few buffers walked by the consumed count, mostly closed by a finish
    task automatic run_load();
        int          n_buf;
        int          cap;
        logic [31:0] addr;
        logic [31:0] tail;
        logic [23:0] left;
        bit          lead;
        n_buf = $urandom_range(1, 5);
        lead  = ($urandom_range(9) != 0);
        tail  = pick_addr();
        for (int b = 0; b < n_buf; b++) begin
            addr = (b > 0 && $urandom_range(1) == 1) ? tail : pick_addr();
            left = pick_len();
            cap  = $urandom_range(1, 10);
            for (int k = 0; k < cap; k++) begin
                send_item(KIND_PIECE, addr, left, lead && b == 0 && k == 0);
                if (book.last_consumed == 0)
                    break;
                addr = addr + 32'(book.last_consumed);
                left = left - book.last_consumed;
                tail = addr;
                if (left == 0)
                    break;
            end
        end
        if ($urandom_range(9) != 0)
            send_finish();
    endtask

    task automatic random_traffic(int n);
        int target;
        target = items_sent + n;
        while (items_sent < target) begin
            if ($urandom_range(99) < 12)
                send_item($urandom_range(3) == 0 ? KIND_FINISH : KIND_PIECE, $urandom,
                          $urandom_range(1) ? pick_len() : 24'($urandom), 1'($urandom));
            else
                run_load();
        end
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: empty finish, zero length, address wrap, merges
        send_finish();
        send_item(KIND_PIECE, 32'h0000_0000, 24'd0, 1'b1);
        send_item(KIND_PIECE, 32'hFFFF_F000, 24'hFF_FFFF, 1'b0);
        send_item(KIND_PIECE, 32'h0000_0000, 24'd5000, 1'b0);
        send_item(KIND_PIECE, 32'h1234_5678, 24'd100, 1'b0);
        send_item(KIND_PIECE, 32'h1234_56DC, 24'hFF_FFFF, 1'b0);
        send_item(KIND_PIECE, 32'h0000_1FFF, 24'd1, 1'b1);
        send_item(KIND_PIECE, 32'h0000_2000, 24'h01_0000, 1'b0);
        send_finish();
        send_item(KIND_PIECE, 32'h0000_0000, 24'd1, 1'b0);
        send_item(KIND_PIECE, 32'h8000_0000, 24'd0, 1'b0);
        send_finish();
        random_traffic(50);
        settle();

        // boundary split, then running out of slots and recovering
        set_config(32'd8192, 24'd12288, 9'd4);
        send_item(KIND_PIECE, 32'h0000_1F00, 24'h00_3000, 1'b1);
        send_item(KIND_PIECE, 32'h0000_2000, 24'h00_2F00, 1'b0);
        send_item(KIND_PIECE, 32'h0000_3000, 24'h00_1F00, 1'b0);
        send_finish();
        scatter(6);
        send_item(KIND_PIECE, 32'h0004_0000, 24'd500, 1'b0);
        send_finish();
        scatter(6);
        send_item(KIND_PIECE, 32'h0005_0000, 24'd700, 1'b1);
        send_finish();
        random_traffic(70);
        settle();

        set_config(32'h8000_0000, 24'hFF_FFFF, 9'd256);
        random_traffic(60);
        settle();

        // every slot used once
        set_config(32'd256, 24'd1, 9'd256);
        scatter(256);
        send_finish();
        random_traffic(30);
        settle();

        set_config(32'd3000, 24'd5000, 9'd1);
        random_traffic(50);
        settle();

        set_config(32'd1, 24'd65536, 9'd200);
        random_traffic(40);
        settle();

        calm = 1'b1;
        set_config(32'h0001_0000, 24'd65536, 9'd32);
        random_traffic(70);
        settle();
        calm = 1'b0;

        set_config(32'd4096, 24'd300000, 9'd64);
        hold_req = 1'b1;
        random_traffic(80);
        settle();

        if (book.errors == 0 && book.pending() == 0)
            $display("tb_dma_scatter_gather_builder: done, clean");
        else
            $display("tb_dma_scatter_gather_builder: done, errors");
        $finish;
    end

endmodule
